[src/assert_macros.svh]
// Assertion macros used by the RTL of the stack engine (lse_back).
// Each macro expects clk_i and rst_ni to be in scope at the point of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define LSE_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("stack engine check failed");

// Whenever ante holds, cons must hold in the same cycle.
`define LSE_ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("stack engine check failed");

`endif

[src/lse_pkg.sv]
// Package for the LIFO stack engine: widths, command and status codes,
// queue entry type and back-end state type. No dependencies.
package lse_pkg;

  localparam int unsigned DEPTH_DEF = 64;
  localparam int unsigned QDEPTH    = 2;
  localparam int unsigned VAL_W     = 32;
  localparam int unsigned KIND_W    = 3;
  localparam int unsigned STAT_W    = 3;

  // command codes as they arrive on the input channel
  localparam logic [KIND_W-1:0] KIND_PUSH = 3'd0;
  localparam logic [KIND_W-1:0] KIND_PALL = 3'd1;
  localparam logic [KIND_W-1:0] KIND_PEEK = 3'd2;
  localparam logic [KIND_W-1:0] KIND_SWAP = 3'd3;
  localparam logic [KIND_W-1:0] KIND_POP  = 3'd4;

  localparam logic [STAT_W-1:0] ST_OK         = 3'd0;
  localparam logic [STAT_W-1:0] ST_PEEK_EMPTY = 3'd1;
  localparam logic [STAT_W-1:0] ST_SWAP_SHORT = 3'd2;
  localparam logic [STAT_W-1:0] ST_POP_EMPTY  = 3'd3;
  localparam logic [STAT_W-1:0] ST_PUSH_FULL  = 3'd4;

  typedef enum logic [2:0] {
    OP_PUSH,
    OP_PALL,
    OP_PEEK,
    OP_SWAP,
    OP_POP,
    OP_NOP
  } op_e;

  typedef struct packed {
    op_e                     op;
    logic signed [VAL_W-1:0] value;
  } cmd_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_SWAP_WR1,
    S_SWAP_WR2
  } state_e;

endpackage

[src/lse_if.sv]
// Valid/ready channel interfaces of the stack engine.
// Depends on lse_pkg for field widths.
interface lse_in_if;
  logic                              valid;
  logic                              ready;
  logic [lse_pkg::KIND_W-1:0]        kind;
  logic signed [lse_pkg::VAL_W-1:0]  push_value;

  modport source (output valid, kind, push_value, input ready);
  modport sink   (input valid, kind, push_value, output ready);
endinterface

interface lse_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [lse_pkg::VAL_W-1:0]  out_value;
  logic                              value_valid;
  logic [lse_pkg::STAT_W-1:0]        status;
  logic                              last;

  modport source (output valid, out_value, value_valid, status, last, input ready);
  modport sink   (input valid, out_value, value_valid, status, last, output ready);
endinterface

[src/lifo_stack_engine.sv]
// LIFO stack engine of DEPTH signed 32-bit entries, one command per input
// transaction. Commands land in a two-entry queue and are carried out by a
// back-end sequencer; each result transaction sits in an output register;
// while one waits unread the back end takes no new command, though the queue
// still fills. Push, pop, invalid codes and every error finish on acceptance;
// peek: accept, registered read of the top entry, load of the output register;
// swap reads both entries, then does two writes through the single write port;
// print all reads one entry per cycle while the output register is free,
// walking the read port from top to bottom. The memory needs no clearing after
// reset. Depends on lse_pkg, lse_if.sv, lse_front, lse_fifo and lse_back.
module lifo_stack_engine #(
  parameter int unsigned DEPTH = lse_pkg::DEPTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  lse_in_if.sink    in_i,
  lse_out_if.source out_o
);

  lse_pkg::cmd_t front_cmd, back_cmd;
  logic          front_valid, front_ready, back_valid, back_ready;

  lse_front u_front (
    .in_i        (in_i),
    .cmd_o       (front_cmd),
    .cmd_valid_o (front_valid),
    .cmd_ready_i (front_ready)
  );

  lse_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_cmd_i   (front_cmd),
    .wr_valid_i (front_valid),
    .wr_ready_o (front_ready),
    .rd_cmd_o   (back_cmd),
    .rd_valid_o (back_valid),
    .rd_ready_i (back_ready)
  );

  lse_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (back_cmd),
    .cmd_valid_i (back_valid),
    .cmd_ready_o (back_ready),
    .out_o       (out_o)
  );

endmodule

[src/lse_front.sv]
// Front end: takes input transactions and classifies the command code.
// Depends on lse_pkg and lse_in_if.
module lse_front (
  lse_in_if.sink        in_i,
  output lse_pkg::cmd_t cmd_o,
  output logic          cmd_valid_o,
  input  logic          cmd_ready_i
);

  lse_pkg::op_e op;

  always_comb begin
    unique case (in_i.kind)
      lse_pkg::KIND_PUSH: op = lse_pkg::OP_PUSH;
      lse_pkg::KIND_PALL: op = lse_pkg::OP_PALL;
      lse_pkg::KIND_PEEK: op = lse_pkg::OP_PEEK;
      lse_pkg::KIND_SWAP: op = lse_pkg::OP_SWAP;
      lse_pkg::KIND_POP:  op = lse_pkg::OP_POP;
      default:            op = lse_pkg::OP_NOP;
    endcase
  end

  assign cmd_o.op    = op;
  assign cmd_o.value = in_i.push_value;
  assign cmd_valid_o = in_i.valid;
  assign in_i.ready  = cmd_ready_i;

endmodule

[src/lse_fifo.sv]
// Short command queue between front and back end.
// Depends on lse_pkg.
module lse_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  lse_pkg::cmd_t wr_cmd_i,
  input  logic          wr_valid_i,
  output logic          wr_ready_o,
  output lse_pkg::cmd_t rd_cmd_o,
  output logic          rd_valid_o,
  input  logic          rd_ready_i
);

  localparam int unsigned PW = (lse_pkg::QDEPTH > 1) ? $clog2(lse_pkg::QDEPTH) : 1;
  localparam int unsigned NW = $clog2(lse_pkg::QDEPTH + 1);

  lse_pkg::cmd_t   entry_q [lse_pkg::QDEPTH];
  logic [PW-1:0]   wptr_q, wptr_d, rptr_q, rptr_d;
  logic [NW-1:0]   num_q, num_d;
  logic            push, pop;

  assign wr_ready_o = (num_q != NW'(lse_pkg::QDEPTH));
  assign rd_valid_o = (num_q != '0);
  assign rd_cmd_o   = entry_q[rptr_q];
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    num_d  = num_q;
    if (push) begin
      wptr_d = (wptr_q == PW'(lse_pkg::QDEPTH - 1)) ? '0 : wptr_q + PW'(1);
    end
    if (pop) begin
      rptr_d = (rptr_q == PW'(lse_pkg::QDEPTH - 1)) ? '0 : rptr_q + PW'(1);
    end
    if (push && !pop) begin
      num_d = num_q + NW'(1);
    end else if (pop && !push) begin
      num_d = num_q - NW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      num_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      num_q  <= num_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wptr_q] <= wr_cmd_i;
    end
  end

endmodule

[src/lse_back.sv]
// Back end: stack memory, entry count and the command sequencer,
// plus the output register. Depends on lse_pkg, lse_out_if, assert_macros.svh.
`include "assert_macros.svh"

module lse_back #(
  parameter int unsigned DEPTH = lse_pkg::DEPTH_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  lse_pkg::cmd_t cmd_i,
  input  logic          cmd_valid_i,
  output logic          cmd_ready_o,
  lse_out_if.source     out_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned VW = lse_pkg::VAL_W;
  localparam int unsigned SW = lse_pkg::STAT_W;

  logic signed [VW-1:0] mem_q [DEPTH];

  lse_pkg::state_e state_q, state_d;
  logic [CW-1:0]   count_q, count_d;
  logic [AW-1:0]   ptr_q, ptr_d;
  logic            go_q, go_d, single_q, single_d;
  logic            rdv_q, rdv_d, rd_last_q, rd_last_d;

  logic                 wr_en, rda_en, rdb_en;
  logic [AW-1:0]        wr_addr, rda_addr, rdb_addr;
  logic signed [VW-1:0] wr_data, rda_q, rdb_q;

  logic                 ov_q, ov_d;
  logic signed [VW-1:0] oval_q, oval_d;
  logic                 ovv_q, ovv_d, olast_q, olast_d;
  logic [SW-1:0]        ost_q, ost_d;
  logic                 load_out;

  logic          out_free, empty, full, two;
  logic [AW-1:0] top_addr, below_addr;

  assign out_free   = !ov_q || out_o.ready;
  assign empty      = (count_q == '0);
  assign full       = (count_q == CW'(DEPTH));
  assign two        = (count_q >= CW'(2));
  assign top_addr   = AW'(count_q - CW'(1));
  assign below_addr = AW'(count_q - CW'(2));

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lse_pkg::S_IDLE: begin
        if (cmd_valid_i && out_free) begin
          if ((cmd_i.op == lse_pkg::OP_PALL || cmd_i.op == lse_pkg::OP_PEEK) && !empty) begin
            state_d = lse_pkg::S_WALK;
          end else if (cmd_i.op == lse_pkg::OP_SWAP && two) begin
            state_d = lse_pkg::S_SWAP_WR1;
          end
        end
      end
      lse_pkg::S_WALK: begin
        if (!go_q && (!rdv_q || out_free)) begin
          state_d = lse_pkg::S_IDLE;
        end
      end
      lse_pkg::S_SWAP_WR1: state_d = lse_pkg::S_SWAP_WR2;
      lse_pkg::S_SWAP_WR2: begin
        if (out_free) begin
          state_d = lse_pkg::S_IDLE;
        end
      end
      default: state_d = lse_pkg::S_IDLE;
    endcase
  end

  // sequencer outputs and datapath
  always_comb begin
    cmd_ready_o = 1'b0;
    count_d     = count_q;
    ptr_d       = ptr_q;
    go_d        = go_q;
    single_d    = single_q;
    rdv_d       = rdv_q;
    rd_last_d   = rd_last_q;
    wr_en       = 1'b0;
    wr_addr     = top_addr;
    wr_data     = cmd_i.value;
    rda_en      = 1'b0;
    rda_addr    = top_addr;
    rdb_en      = 1'b0;
    rdb_addr    = below_addr;
    load_out    = 1'b0;
    oval_d      = '0;
    ovv_d       = 1'b0;
    ost_d       = lse_pkg::ST_OK;
    olast_d     = 1'b1;

    unique case (state_q)
      lse_pkg::S_IDLE: begin
        if (cmd_valid_i && out_free) begin
          cmd_ready_o = 1'b1;
          unique case (cmd_i.op)
            lse_pkg::OP_PUSH: begin
              load_out = 1'b1;
              if (full) begin
                ost_d = lse_pkg::ST_PUSH_FULL;
              end else begin
                wr_en   = 1'b1;
                wr_addr = AW'(count_q);
                count_d = count_q + CW'(1);
              end
            end
            lse_pkg::OP_PALL, lse_pkg::OP_PEEK: begin
              if (empty) begin
                load_out = 1'b1;
                if (cmd_i.op == lse_pkg::OP_PEEK) begin
                  ost_d = lse_pkg::ST_PEEK_EMPTY;
                end
              end else begin
                ptr_d    = top_addr;
                go_d     = 1'b1;
                single_d = (cmd_i.op == lse_pkg::OP_PEEK);
              end
            end
            lse_pkg::OP_SWAP: begin
              if (two) begin
                rda_en = 1'b1;
                rdb_en = 1'b1;
              end else begin
                load_out = 1'b1;
                ost_d    = lse_pkg::ST_SWAP_SHORT;
              end
            end
            lse_pkg::OP_POP: begin
              load_out = 1'b1;
              if (empty) begin
                ost_d = lse_pkg::ST_POP_EMPTY;
              end else begin
                count_d = count_q - CW'(1);
              end
            end
            default: load_out = 1'b1;
          endcase
        end
      end
      lse_pkg::S_WALK: begin
        // read data waits in rda_q until the output register frees up
        if (rdv_q && out_free) begin
          load_out = 1'b1;
          oval_d   = rda_q;
          ovv_d    = 1'b1;
          olast_d  = rd_last_q;
        end
        if (go_q && (!rdv_q || out_free)) begin
          rda_en    = 1'b1;
          rda_addr  = ptr_q;
          rd_last_d = single_q || (ptr_q == '0);
          if (single_q || (ptr_q == '0)) begin
            go_d = 1'b0;
          end else begin
            ptr_d = ptr_q - AW'(1);
          end
          rdv_d = 1'b1;
        end else if (rdv_q && out_free) begin
          rdv_d = 1'b0;
        end
      end
      lse_pkg::S_SWAP_WR1: begin
        wr_en   = 1'b1;
        wr_addr = top_addr;
        wr_data = rdb_q;
      end
      lse_pkg::S_SWAP_WR2: begin
        if (out_free) begin
          wr_en    = 1'b1;
          wr_addr  = below_addr;
          wr_data  = rda_q;
          load_out = 1'b1;
        end
      end
      default: ;
    endcase

    ov_d = load_out ? 1'b1 : (out_o.ready ? 1'b0 : ov_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= lse_pkg::S_IDLE;
      count_q   <= '0;
      go_q      <= 1'b0;
      rdv_q     <= 1'b0;
      ov_q      <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      go_q      <= go_d;
      rdv_q     <= rdv_d;
      ov_q      <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q     <= ptr_d;
    single_q  <= single_d;
    rd_last_q <= rd_last_d;
    if (load_out) begin
      oval_q  <= oval_d;
      ovv_q   <= ovv_d;
      ost_q   <= ost_d;
      olast_q <= olast_d;
    end
  end

  // stack memory: one write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rda_en) begin
      rda_q <= mem_q[rda_addr];
    end
    if (rdb_en) begin
      rdb_q <= mem_q[rdb_addr];
    end
  end

  assign out_o.valid       = ov_q;
  assign out_o.out_value   = oval_q;
  assign out_o.value_valid = ovv_q;
  assign out_o.status      = ost_q;
  assign out_o.last        = olast_q;

  `LSE_ASSERT_ALWAYS(a_count_bound, count_q <= CW'(DEPTH))
  `LSE_ASSERT_IMPLIES(a_swap_depth, state_q == lse_pkg::S_SWAP_WR1 || state_q == lse_pkg::S_SWAP_WR2, two)
  `LSE_ASSERT_IMPLIES(a_rd_in_walk, rdv_q, state_q == lse_pkg::S_WALK)
  `LSE_ASSERT_IMPLIES(a_no_overwrite, ov_q && !out_o.ready, !load_out)

endmodule

[sim/tb_lifo_stack_engine.sv]
`timescale 1ns / 100ps
// Self-checking bench for lifo_stack_engine: directed corner commands, then random
// push/pop/peek/swap/print-all/junk sequences, checked against a local stack model.
// Depends on lse_pkg, the channel interfaces in lse_if.sv and the engine RTL.
module tb_lifo_stack_engine;
  import lse_pkg::*;

  localparam int unsigned    STK_DEPTH    = DEPTH_DEF;
  localparam int unsigned    N_RANDOM     = 350;
  localparam int unsigned    CALM_TAIL    = 60;
  localparam int unsigned    HOLD_AT      = 60;
  localparam int unsigned    LONG_HOLD    = 300;
  localparam int unsigned    DRAIN_CYCLES = 100;
  localparam longint         CYCLE_LIMIT  = 1_000_000;
  localparam time            CLK_PERIOD   = 10ns;

  // reserved codes: no stack change, the engine answers each with a plain OK
  localparam logic [KIND_W-1:0] KIND_RSVD_LO = 3'd5;
  localparam logic [KIND_W-1:0] KIND_RSVD_HI = 3'd7;

  localparam logic signed [VAL_W-1:0] VAL_MAX  = 32'sh7FFF_FFFF;
  localparam logic signed [VAL_W-1:0] VAL_MIN  = 32'sh8000_0000;
  localparam logic signed [VAL_W-1:0] VAL_NEG1 = -32'sd1;

  typedef struct {
    logic [KIND_W-1:0]       kind;
    logic signed [VAL_W-1:0] value;
    bit                      drain;  // offer only once every result is back
  } cmd_item_t;

  typedef struct {
    logic signed [VAL_W-1:0] value;
    logic                    vvalid;
    logic [STAT_W-1:0]       status;
    logic                    last;
  } result_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  lse_in_if  in_if ();
  lse_out_if out_if ();

  lifo_stack_engine dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  cmd_item_t               cmd_q[$];
  result_t                 pending_results[$];
  logic signed [VAL_W-1:0] model_stack[STK_DEPTH];
  int unsigned             model_count = 0;
  int unsigned             gen_count = 0;
  int unsigned             n_gen = 0;
  int unsigned             total_cmds = 0;
  int unsigned             n_expected = 0;
  int unsigned             n_received = 0;
  int unsigned             n_accepted = 0;
  int unsigned             err_cnt = 0;
  int unsigned             send_gap, recv_gap, hold_left;
  bit                      held;
  bit                      idle_tx = 1'b1;
  bit                      idle_rx = 1'b1;
  longint                  cycles = 0;
  wire                     calm = (total_cmds - n_accepted) <= CALM_TAIL;

  function automatic void expect_result(logic signed [VAL_W-1:0] v, logic vv,
                                        logic [STAT_W-1:0] st, logic lst);
    result_t r;
    r.value  = v;
    r.vvalid = vv;
    r.status = st;
    r.last   = lst;
    pending_results.push_back(r);
  endfunction

  // Applies one command to the model stack; returns the number of results it yields.
  function automatic int stack_step(logic [KIND_W-1:0] kind, logic signed [VAL_W-1:0] v);
    logic signed [VAL_W-1:0] tmp;
    int k;
    k = 1;
    case (kind)
      KIND_PUSH: begin
        if (model_count >= STK_DEPTH) begin
          expect_result('0, 1'b0, ST_PUSH_FULL, 1'b1);
        end else begin
          model_stack[model_count] = v;
          model_count++;
          expect_result('0, 1'b0, ST_OK, 1'b1);
        end
      end
      KIND_PALL: begin
        if (model_count == 0) begin
          expect_result('0, 1'b0, ST_OK, 1'b1);
        end else begin
          k = model_count;
          for (int i = model_count; i > 0; i--)
            expect_result(model_stack[i-1], 1'b1, ST_OK, i == 1);
        end
      end
      KIND_PEEK: begin
        if (model_count == 0) expect_result('0, 1'b0, ST_PEEK_EMPTY, 1'b1);
        else expect_result(model_stack[model_count-1], 1'b1, ST_OK, 1'b1);
      end
      KIND_SWAP: begin
        if (model_count < 2) begin
          expect_result('0, 1'b0, ST_SWAP_SHORT, 1'b1);
        end else begin
          tmp = model_stack[model_count-1];
          model_stack[model_count-1] = model_stack[model_count-2];
          model_stack[model_count-2] = tmp;
          expect_result('0, 1'b0, ST_OK, 1'b1);
        end
      end
      KIND_POP: begin
        if (model_count == 0) begin
          expect_result('0, 1'b0, ST_POP_EMPTY, 1'b1);
        end else begin
          model_count--;
          expect_result('0, 1'b0, ST_OK, 1'b1);
        end
      end
      default: expect_result('0, 1'b0, ST_OK, 1'b1);
    endcase
    return k;
  endfunction

  // Queues a command; gen_count tracks depth only to shape the sequences.
  function automatic void add_cmd(logic [KIND_W-1:0] kind, logic signed [VAL_W-1:0] v,
                                  bit drain = 1'b0);
    cmd_item_t c;
    c.kind  = kind;
    c.value = v;
    c.drain = drain;
    cmd_q.push_back(c);
    if (kind <= KIND_POP) n_gen++;
    if (kind == KIND_PUSH && gen_count < STK_DEPTH) gen_count++;
    if (kind == KIND_POP && gen_count > 0) gen_count--;
  endfunction

  function automatic logic [KIND_W-1:0] pick_kind();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 36) return KIND_PUSH;
    if (r < 44) return KIND_PALL;
    if (r < 58) return KIND_PEEK;
    if (r < 72) return KIND_SWAP;
    if (r < 98) return KIND_POP;
    return KIND_W'($urandom_range(KIND_RSVD_LO, KIND_RSVD_HI));
  endfunction

  // Fill to capacity, overflow a few times, then dump and touch the top.
  function automatic void fill_and_dump();
    while (gen_count < STK_DEPTH) add_cmd(KIND_PUSH, $urandom);
    repeat ($urandom_range(1, 3)) add_cmd(KIND_PUSH, $urandom);
    add_cmd(KIND_PALL, $urandom);
    add_cmd(KIND_SWAP, $urandom);
    add_cmd(KIND_PEEK, $urandom);
  endfunction

  function automatic void check_field(string name, logic [VAL_W-1:0] want,
                                      logic [VAL_W-1:0] got);
    if (got !== want) begin
      err_cnt++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    end
  endfunction

  initial begin
    int unsigned seg;
    rst_ni            = 1'b0;
    in_if.valid       = 1'b0;
    in_if.kind        = KIND_PUSH;
    in_if.push_value  = '0;
    out_if.ready      = 1'b0;

    // errors and junk codes on an empty stack
    add_cmd(KIND_PEEK, $urandom);
    add_cmd(KIND_POP, $urandom);
    add_cmd(KIND_SWAP, $urandom);
    add_cmd(KIND_PALL, $urandom);
    for (int i = KIND_RSVD_LO; i <= KIND_RSVD_HI; i++) add_cmd(KIND_W'(i), $urandom);
    // value extremes, swap with one and two entries
    add_cmd(KIND_PUSH, VAL_MAX);
    add_cmd(KIND_SWAP, $urandom);
    add_cmd(KIND_PEEK, $urandom);
    add_cmd(KIND_PUSH, VAL_MIN);
    add_cmd(KIND_SWAP, $urandom);
    add_cmd(KIND_PEEK, $urandom);
    add_cmd(KIND_PUSH, '0);
    add_cmd(KIND_PUSH, VAL_NEG1);
    add_cmd(KIND_PALL, $urandom);
    add_cmd(KIND_POP, $urandom);
    add_cmd(KIND_POP, $urandom);
    add_cmd(KIND_PALL, $urandom);
    add_cmd(KIND_POP, $urandom);
    add_cmd(KIND_POP, $urandom);
    add_cmd(KIND_POP, $urandom);

    n_gen = 0;
    fill_and_dump();
    add_cmd(KIND_PEEK, $urandom, 1'b1);
    while (n_gen < N_RANDOM) begin
      seg = $urandom_range(0, 19);
      if (seg == 0) begin
        fill_and_dump();
      end else if (seg < 5) begin
        repeat ($urandom_range(4, 16)) add_cmd(KIND_PUSH, $urandom);
        add_cmd(KIND_PALL, $urandom);
      end else if (seg < 8) begin
        repeat ($urandom_range(0, gen_count + 2)) add_cmd(KIND_POP, $urandom);
        add_cmd(pick_kind(), $urandom);
      end else if (seg == 8) begin
        repeat ($urandom_range(2, 5))
          add_cmd(KIND_W'($urandom_range(KIND_RSVD_LO, KIND_RSVD_HI)), $urandom);
      end else begin
        repeat ($urandom_range(6, 20)) add_cmd(pick_kind(), $urandom);
      end
    end
    total_cmds = cmd_q.size();

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    do @(posedge clk_i);
    while (n_accepted != total_cmds || n_received != n_expected);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (err_cnt == 0 && pending_results.size() == 0 && n_received == n_expected) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles[5:0] == 0) begin
      idle_tx <= $urandom_range(0, 2) != 0;
      idle_rx <= $urandom_range(0, 2) != 0;
    end
    if (cycles >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // command driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      send_gap    <= 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        n_expected <= n_expected + stack_step(in_if.kind, in_if.push_value);
        n_accepted <= n_accepted + 1;
      end
      // valid stays up until the transaction completes
      if (!in_if.valid || in_if.ready) begin
        if (send_gap != 0) begin
          in_if.valid <= 1'b0;
          send_gap    <= send_gap - 1;
        end else if (!calm && idle_tx && $urandom_range(0, 7) == 0) begin
          in_if.valid <= 1'b0;
          send_gap    <= $urandom_range(0, 11);
        end else if (cmd_q.size() != 0 &&
                     (!cmd_q[0].drain || (!in_if.valid && n_expected == n_received))) begin
          in_if.valid      <= 1'b1;
          in_if.kind       <= cmd_q[0].kind;
          in_if.push_value <= cmd_q[0].value;
          void'(cmd_q.pop_front());
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // result receiver: random backpressure plus one long hold so the engine backs up
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      recv_gap     <= 0;
      hold_left    <= 0;
      held         <= 1'b0;
    end else if (hold_left != 0) begin
      out_if.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else if (!held && n_accepted >= HOLD_AT) begin
      out_if.ready <= 1'b0;
      hold_left    <= LONG_HOLD - 1;
      held         <= 1'b1;
    end else if (recv_gap != 0) begin
      out_if.ready <= 1'b0;
      recv_gap     <= recv_gap - 1;
    end else if (!calm && idle_rx && $urandom_range(0, 7) == 0) begin
      out_if.ready <= 1'b0;
      recv_gap     <= $urandom_range(0, 11);
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      n_received <= n_received + 1;
      if (pending_results.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected transaction, expected none, got value %0h status %0d",
                 $time, out_if.out_value, out_if.status);
      end else begin
        want = pending_results.pop_front();
        check_field("out_value", want.value, out_if.out_value);
        check_field("value_valid", VAL_W'(want.vvalid), VAL_W'(out_if.value_valid));
        check_field("status", VAL_W'(want.status), VAL_W'(out_if.status));
        check_field("last", VAL_W'(want.last), VAL_W'(out_if.last));
      end
    end
  end

endmodule
